// File: rtl/alc_pkg.sv
// Package for the alarm clock controller: operation and field codes,
// time limits and the alarm state record shared by the step logic and top level.
// No dependencies.
package alc_pkg;

    // Operation codes carried by each input beat
    localparam logic [2:0] OP_UP     = 3'd0;
    localparam logic [2:0] OP_DOWN   = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_SNOOZE = 3'd3;
    localparam logic [2:0] OP_STOP   = 3'd4;
    localparam logic [2:0] OP_ENABLE = 3'd5;

    // Field selected by up/down
    localparam logic [1:0] FIELD_HOUR   = 2'd0;
    localparam logic [1:0] FIELD_MINUTE = 2'd1;

    // Time limits
    localparam logic [3:0] HOURS_HALF    = 4'd12;
    localparam logic [4:0] HOURS_HALF_24 = 5'd12;
    localparam logic [4:0] HOURS_DAY     = 5'd24;
    localparam logic [5:0] MINUTE_LAST   = 6'd59;
    localparam logic [6:0] MINUTES_HOUR  = 7'd60;
    localparam logic [6:0] SNOOZE_MIN    = 7'd10;

    // Reset values of the alarm time
    localparam logic [3:0] HOUR_RESET   = 4'd12;
    localparam logic [5:0] MINUTE_RESET = 6'd0;

    // Stored alarm state
    typedef struct packed {
        logic [3:0] hour;
        logic [5:0] minute;
        logic       pm;
        logic       on;
        logic       ringing;
    } alarm_state_t;

endpackage

// File: rtl/alc_step.sv
// Next-state logic of the alarm clock controller: applies one operation
// to the stored alarm state. Depends on alc_pkg.
module alc_step (
    input  alc_pkg::alarm_state_t cur,
    input  logic [2:0]            op,
    input  logic [1:0]            set_field,
    input  logic [4:0]            now_hour,
    input  logic [5:0]            now_minute,
    input  logic [5:0]            now_second,
    output alc_pkg::alarm_state_t nxt,
    output logic                  started_ringing,
    output logic                  go_home
);

    logic [4:0] hour_mod;
    logic [3:0] hour12;
    logic       now_pm;
    logic       time_match;
    logic [6:0] snooze_sum;

    // Fold the 24-hour clock into 12-hour form, zero read as twelve
    always_comb
    begin
        if (now_hour >= alc_pkg::HOURS_DAY)
        begin
            hour_mod = now_hour - alc_pkg::HOURS_DAY;
        end
        else if (now_hour >= alc_pkg::HOURS_HALF_24)
        begin
            hour_mod = now_hour - alc_pkg::HOURS_HALF_24;
        end
        else
        begin
            hour_mod = now_hour;
        end
        hour12 = (hour_mod == 5'd0) ? alc_pkg::HOURS_HALF : hour_mod[3:0];
        now_pm = (now_hour >= alc_pkg::HOURS_HALF_24);
    end

    assign time_match = (hour12 == cur.hour) && (now_minute == cur.minute)
                        && (now_pm == cur.pm) && (now_second == 6'd0);
    assign snooze_sum = {1'b0, cur.minute} + alc_pkg::SNOOZE_MIN;

    // Apply the operation
    always_comb
    begin
        nxt             = cur;
        started_ringing = 1'b0;
        go_home         = 1'b0;
        unique case (op)
            alc_pkg::OP_UP:
            begin
                unique case (set_field)
                    alc_pkg::FIELD_HOUR:
                        nxt.hour = (cur.hour >= alc_pkg::HOURS_HALF) ? 4'd1 : cur.hour + 4'd1;
                    alc_pkg::FIELD_MINUTE:
                        nxt.minute = (cur.minute >= alc_pkg::MINUTE_LAST) ? 6'd0
                                                                           : cur.minute + 6'd1;
                    default:
                        nxt.pm = ~cur.pm;
                endcase
            end
            alc_pkg::OP_DOWN:
            begin
                unique case (set_field)
                    alc_pkg::FIELD_HOUR:
                        nxt.hour = (cur.hour <= 4'd1) ? alc_pkg::HOURS_HALF : cur.hour - 4'd1;
                    alc_pkg::FIELD_MINUTE:
                        nxt.minute = (cur.minute == 6'd0) ? alc_pkg::MINUTE_LAST
                                                          : cur.minute - 6'd1;
                    default:
                        nxt.pm = ~cur.pm;
                endcase
            end
            alc_pkg::OP_TICK:
            begin
                // Start ringing only while armed and quiet
                if (cur.on && !cur.ringing && time_match)
                begin
                    nxt.ringing     = 1'b1;
                    started_ringing = 1'b1;
                end
            end
            alc_pkg::OP_SNOOZE:
            begin
                nxt.ringing = 1'b0;
                nxt.on      = 1'b1;
                go_home     = 1'b1;
                if (snooze_sum >= alc_pkg::MINUTES_HOUR)
                begin
                    nxt.minute = 6'(snooze_sum - alc_pkg::MINUTES_HOUR);
                    // Carry into the hour; toggle half of day on reaching twelve
                    if (cur.hour >= alc_pkg::HOURS_HALF)
                    begin
                        nxt.hour = 4'd1;
                    end
                    else
                    begin
                        nxt.hour = cur.hour + 4'd1;
                        if (cur.hour + 4'd1 == alc_pkg::HOURS_HALF)
                        begin
                            nxt.pm = ~cur.pm;
                        end
                    end
                end
                else
                begin
                    nxt.minute = snooze_sum[5:0];
                end
            end
            alc_pkg::OP_STOP:
            begin
                nxt.ringing = 1'b0;
                nxt.on      = 1'b0;
                go_home     = 1'b1;
            end
            alc_pkg::OP_ENABLE:
            begin
                nxt.on = 1'b1;
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

endmodule

// File: rtl/alarm_clock_controller.sv
// Top level of the alarm clock controller: input register, alarm state,
// result register. Depends on alc_pkg and alc_step.
//
// Usage:
//   Input channel (item_valid/item_ready) carries one operation per beat:
//   op, set_field and the current time now_hour/now_minute/now_second.
//   Result channel (result_valid/result_ready) returns exactly one beat per
//   input beat, in order: the alarm time, enable and ringing flags after the
//   operation, plus the started_ringing and go_home pulses.
//   Throughput: one beat per cycle unless result_ready holds the result
//   register; the state update is a single pass of the step logic between
//   the input register and the state/result registers.
//   Stall: when result_ready is low the result register holds, the input
//   register fills, and item_ready drops; no beat is lost or repeated.
//   Reset: rst_n low clears both valid flags and loads the alarm state with
//   12:00 AM, alarm off, not ringing.
module alarm_clock_controller (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  logic [2:0] op,
    input  logic [1:0] set_field,
    input  logic [4:0] now_hour,
    input  logic [5:0] now_minute,
    input  logic [5:0] now_second,
    output logic       result_valid,
    input  logic       result_ready,
    output logic [3:0] alarm_hour,
    output logic [5:0] alarm_minute,
    output logic       alarm_pm,
    output logic       alarm_on,
    output logic       is_ringing,
    output logic       started_ringing,
    output logic       go_home
);

    logic                  item_valid_reg;
    logic [2:0]            op_reg;
    logic [1:0]            set_field_reg;
    logic [4:0]            now_hour_reg;
    logic [5:0]            now_minute_reg;
    logic [5:0]            now_second_reg;
    alc_pkg::alarm_state_t state_reg;
    alc_pkg::alarm_state_t state_next;
    logic                  started_next;
    logic                  home_next;
    logic                  result_valid_reg;
    alc_pkg::alarm_state_t result_state_reg;
    logic                  started_reg;
    logic                  home_reg;
    logic                  advance;

    // Move a beat from the input register when the result register frees up
    assign advance    = item_valid_reg && (!result_valid_reg || result_ready);
    assign item_ready = !item_valid_reg || advance;

    // Input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (item_ready)
        begin
            item_valid_reg <= item_valid;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            op_reg         <= op;
            set_field_reg  <= set_field;
            now_hour_reg   <= now_hour;
            now_minute_reg <= now_minute;
            now_second_reg <= now_second;
        end
    end

    alc_step u_step (
        .cur             (state_reg),
        .op              (op_reg),
        .set_field       (set_field_reg),
        .now_hour        (now_hour_reg),
        .now_minute      (now_minute_reg),
        .now_second      (now_second_reg),
        .nxt             (state_next),
        .started_ringing (started_next),
        .go_home         (home_next)
    );

    // Alarm state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.hour    <= alc_pkg::HOUR_RESET;
            state_reg.minute  <= alc_pkg::MINUTE_RESET;
            state_reg.pm      <= 1'b0;
            state_reg.on      <= 1'b0;
            state_reg.ringing <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_state_reg <= state_next;
            started_reg      <= started_next;
            home_reg         <= home_next;
        end
    end

    assign result_valid    = result_valid_reg;
    assign alarm_hour      = result_state_reg.hour;
    assign alarm_minute    = result_state_reg.minute;
    assign alarm_pm        = result_state_reg.pm;
    assign alarm_on        = result_state_reg.on;
    assign is_ringing      = result_state_reg.ringing;
    assign started_ringing = started_reg;
    assign go_home         = home_reg;

endmodule

// File: rtl/alc_checker.sv
// Port-level checks for the alarm clock controller and their bind.
// Depends on alarm_clock_controller.
module alc_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       result_valid,
    input logic       result_ready,
    input logic [3:0] alarm_hour,
    input logic [5:0] alarm_minute,
    input logic       alarm_on,
    input logic       is_ringing,
    input logic       started_ringing,
    input logic       go_home
);

    // Hold a stalled result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(alarm_hour)
            && $stable(alarm_minute) && $stable(is_ringing))
        else $error("stalled result beat changed");

    // Keep the alarm hour in 1..12
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alarm_hour >= 4'd1 && alarm_hour <= 4'd12)
        else $error("alarm hour out of range");

    // Keep the alarm minute in 0..59
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> alarm_minute <= 6'd59)
        else $error("alarm minute out of range");

    // A start of ringing leaves the alarm armed and ringing, never with a home request
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && started_ringing |-> is_ringing && alarm_on && !go_home)
        else $error("started ringing with inconsistent flags");

    // Snooze and stop always silence the alarm
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && go_home |-> !is_ringing)
        else $error("home request while ringing");

endmodule

bind alarm_clock_controller alc_checker u_alc_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .result_valid    (result_valid),
    .result_ready    (result_ready),
    .alarm_hour      (alarm_hour),
    .alarm_minute    (alarm_minute),
    .alarm_on        (alarm_on),
    .is_ringing      (is_ringing),
    .started_ringing (started_ringing),
    .go_home         (go_home)
);

// File: tb/tb_top.sv
// Testbench for alarm_clock_controller: directed and random operation beats,
// checked field by field against an in-bench model of the alarm state.
// Depends on alc_pkg and the alarm_clock_controller RTL.
module tb_top;

    // Codes the package leaves unnamed
    localparam logic [1:0] FIELD_PM    = 2'd2;
    localparam logic [1:0] FIELD_SPARE = 2'd3;
    localparam logic [2:0] OP_SPARE_6  = 3'd6;
    localparam logic [2:0] OP_SPARE_7  = 3'd7;

    localparam int LONG_HOLD   = 80;
    localparam int DRAIN_WAIT  = 10;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic [3:0] hour;
        logic [5:0] minute;
        logic       pm;
        logic       on;
        logic       ringing;
        logic       started;
        logic       home;
    } alarm_result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    logic [2:0] op = '0;
    logic [1:0] set_field = '0;
    logic [4:0] now_hour = '0;
    logic [5:0] now_minute = '0;
    logic [5:0] now_second = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    logic [3:0] alarm_hour;
    logic [5:0] alarm_minute;
    logic       alarm_pm;
    logic       alarm_on;
    logic       is_ringing;
    logic       started_ringing;
    logic       go_home;

    // Model of the alarm state
    logic [3:0] model_hour = alc_pkg::HOUR_RESET;
    logic [5:0] model_minute = alc_pkg::MINUTE_RESET;
    logic       model_pm = 1'b0;
    logic       model_on = 1'b0;
    logic       model_ringing = 1'b0;

    alarm_result_t expected_results[$];

    bit gaps_on = 1'b1;
    bit stalls_on = 1'b1;
    bit hold_req = 1'b0;
    int beats_sent = 0;
    int results_checked = 0;
    int alarm_starts = 0;
    int home_requests = 0;
    int long_holds = 0;
    int mismatches = 0;
    int cycle_count = 0;

    alarm_clock_controller i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .op              (op),
        .set_field       (set_field),
        .now_hour        (now_hour),
        .now_minute      (now_minute),
        .now_second      (now_second),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .alarm_hour      (alarm_hour),
        .alarm_minute    (alarm_minute),
        .alarm_pm        (alarm_pm),
        .alarm_on        (alarm_on),
        .is_ringing      (is_ringing),
        .started_ringing (started_ringing),
        .go_home         (go_home)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Advance the alarm model by one operation and return the state it reports
    function automatic alarm_result_t predict_alarm_beat(input logic [2:0] code,
                                                         input logic [1:0] fld,
                                                         input logic [4:0] hh,
                                                         input logic [5:0] mm,
                                                         input logic [5:0] ss);
        alarm_result_t res;
        logic [4:0]    hh12;
        logic [6:0]    mins;
        res = '0;
        case (code)
            alc_pkg::OP_UP, alc_pkg::OP_DOWN:
            begin
                if (fld == alc_pkg::FIELD_HOUR)
                begin
                    if (code == alc_pkg::OP_UP)
                        model_hour = (model_hour >= alc_pkg::HOURS_HALF) ? 4'd1
                                                                         : model_hour + 4'd1;
                    else
                        model_hour = (model_hour <= 4'd1) ? alc_pkg::HOURS_HALF
                                                          : model_hour - 4'd1;
                end
                else if (fld == alc_pkg::FIELD_MINUTE)
                begin
                    if (code == alc_pkg::OP_UP)
                        model_minute = (model_minute >= alc_pkg::MINUTE_LAST)
                                       ? 6'd0 : model_minute + 6'd1;
                    else
                        model_minute = (model_minute == 6'd0)
                                       ? alc_pkg::MINUTE_LAST : model_minute - 6'd1;
                end
                else
                    model_pm = ~model_pm;
            end
            alc_pkg::OP_TICK:
            begin
                // Match only while armed and quiet; hours past 23 still count as PM
                if (model_on && !model_ringing)
                begin
                    hh12 = hh % alc_pkg::HOURS_HALF_24;
                    if (hh12 == 5'd0)
                        hh12 = alc_pkg::HOURS_HALF_24;
                    if (hh12[3:0] == model_hour && mm == model_minute
                        && (hh >= alc_pkg::HOURS_HALF_24) == model_pm && ss == 6'd0)
                    begin
                        model_ringing = 1'b1;
                        res.started   = 1'b1;
                    end
                end
            end
            alc_pkg::OP_SNOOZE:
            begin
                // Push ten minutes later; entering hour 12 flips the half of day
                model_ringing = 1'b0;
                model_on      = 1'b1;
                mins          = {1'b0, model_minute} + alc_pkg::SNOOZE_MIN;
                if (mins >= alc_pkg::MINUTES_HOUR)
                begin
                    mins = mins - alc_pkg::MINUTES_HOUR;
                    if (model_hour >= alc_pkg::HOURS_HALF)
                        model_hour = 4'd1;
                    else
                    begin
                        model_hour = model_hour + 4'd1;
                        if (model_hour == alc_pkg::HOURS_HALF)
                            model_pm = ~model_pm;
                    end
                end
                model_minute = mins[5:0];
                res.home     = 1'b1;
            end
            alc_pkg::OP_STOP:
            begin
                model_ringing = 1'b0;
                model_on      = 1'b0;
                res.home      = 1'b1;
            end
            alc_pkg::OP_ENABLE:
                model_on = 1'b1;
            default: ;
        endcase
        res.hour    = model_hour;
        res.minute  = model_minute;
        res.pm      = model_pm;
        res.on      = model_on;
        res.ringing = model_ringing;
        return res;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Predict on each accepted input beat, compare each accepted result beat
    always @(posedge clk)
    begin
        alarm_result_t want;
        if (rst_n)
        begin
            if (item_valid && item_ready)
            begin
                expected_results.push_back(
                    predict_alarm_beat(op, set_field, now_hour, now_minute, now_second));
                beats_sent++;
            end
            if (result_valid && result_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result beat with nothing expected, expected none,%s",
                             $time, " actual");
                    $display("    %0d:%0d", alarm_hour, alarm_minute);
                end
                else
                begin
                    want = expected_results.pop_front();
                    check_field("alarm_hour", int'(want.hour), int'(alarm_hour));
                    check_field("alarm_minute", int'(want.minute), int'(alarm_minute));
                    check_field("alarm_pm", int'(want.pm), int'(alarm_pm));
                    check_field("alarm_on", int'(want.on), int'(alarm_on));
                    check_field("is_ringing", int'(want.ringing), int'(is_ringing));
                    check_field("started_ringing", int'(want.started),
                                int'(started_ringing));
                    check_field("go_home", int'(want.home), int'(go_home));
                    results_checked++;
                    alarm_starts  += int'(want.started);
                    home_requests += int'(want.home);
                end
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results pending",
                     cycle_count, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Drive result_ready: long hold on request, random stall bursts, open stretches
    initial
    begin
        int hold_left;
        int span;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                result_ready <= 1'b0;
                hold_left = LONG_HOLD;
                while (hold_left > 0)
                begin
                    @(posedge clk);
                    hold_left--;
                end
                hold_req = 1'b0;
                long_holds++;
            end
            else if (stalls_on && $urandom_range(0, 3) == 0)
            begin
                result_ready <= 1'b0;
                span = $urandom_range(1, 10);
                repeat (span) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                span = $urandom_range(1, 12);
                repeat (span) @(posedge clk);
            end
        end
    end

    // Offer one beat, after an optional gap, and hold it until accepted
    task automatic send_beat(input logic [2:0] code, input logic [1:0] fld,
                             input logic [4:0] hh, input logic [5:0] mm,
                             input logic [5:0] ss);
        int span;
        if (gaps_on && $urandom_range(0, 2) == 0)
        begin
            item_valid <= 1'b0;
            span = $urandom_range(1, 10);
            repeat (span) @(posedge clk);
        end
        item_valid <= 1'b1;
        op         <= code;
        set_field  <= fld;
        now_hour   <= hh;
        now_minute <= mm;
        now_second <= ss;
        do
            @(posedge clk);
        while (!item_ready);
    endtask

    // Pick a random operation; many ticks aim at the stored alarm time
    task automatic send_random_beat();
        int         pick;
        int         h24;
        logic [2:0] code;
        logic [4:0] hh;
        logic [5:0] mm;
        logic [5:0] ss;
        pick = $urandom_range(0, 99);
        hh   = 5'($urandom_range(0, 31));
        mm   = 6'($urandom_range(0, 63));
        ss   = 6'($urandom_range(0, 63));
        if (pick < 20)
            code = alc_pkg::OP_UP;
        else if (pick < 35)
            code = alc_pkg::OP_DOWN;
        else if (pick < 70)
        begin
            code = alc_pkg::OP_TICK;
            case ($urandom_range(0, 3))
                0, 1:
                begin
                    h24 = (model_hour == alc_pkg::HOURS_HALF) ? 0 : int'(model_hour);
                    if (model_pm)
                        h24 += 12;
                    if (model_pm && h24 + 12 <= 31 && $urandom_range(0, 1) == 1)
                        h24 += 12;
                    hh = 5'(h24);
                    mm = model_minute;
                    ss = ($urandom_range(0, 4) == 0) ? 6'($urandom_range(1, 63)) : 6'd0;
                end
                2:
                begin
                    hh = 5'($urandom_range(0, 23));
                    mm = 6'($urandom_range(0, 59));
                    ss = 6'($urandom_range(0, 59));
                end
                default: ;
            endcase
        end
        else if (pick < 78)
            code = alc_pkg::OP_SNOOZE;
        else if (pick < 84)
            code = alc_pkg::OP_STOP;
        else if (pick < 96)
            code = alc_pkg::OP_ENABLE;
        else
            code = ($urandom_range(0, 1) == 1) ? OP_SPARE_7 : OP_SPARE_6;
        send_beat(code, 2'($urandom_range(0, 3)), hh, mm, ss);
    endtask

    // Wrap every field both ways from the reset time 12:00 AM
    task automatic test_field_wrap();
        send_beat(alc_pkg::OP_UP, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_DOWN, alc_pkg::FIELD_HOUR, 5'd31, 6'd63, 6'd63);
        send_beat(alc_pkg::OP_DOWN, alc_pkg::FIELD_MINUTE, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_UP, alc_pkg::FIELD_MINUTE, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_UP, FIELD_PM, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_DOWN, FIELD_PM, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_UP, FIELD_SPARE, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_DOWN, FIELD_SPARE, 5'd0, 6'd0, 6'd0);
    endtask

    // Ring on a match, ignore ticks while ringing, stop, then match past hour 23
    task automatic test_ring_and_stop();
        send_beat(alc_pkg::OP_ENABLE, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_TICK, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_TICK, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_ENABLE, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_STOP, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_UP, FIELD_PM, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_ENABLE, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_TICK, alc_pkg::FIELD_HOUR, 5'd24, 6'd63, 6'd0);
        send_beat(alc_pkg::OP_TICK, alc_pkg::FIELD_HOUR, 5'd24, 6'd0, 6'd63);
        send_beat(alc_pkg::OP_TICK, alc_pkg::FIELD_HOUR, 5'd24, 6'd0, 6'd0);
    endtask

    // Walk to 11:55 PM and snooze across midnight to 12:05 AM
    task automatic test_snooze_carry();
        send_beat(alc_pkg::OP_DOWN, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
        repeat (5) send_beat(alc_pkg::OP_DOWN, alc_pkg::FIELD_MINUTE, 5'd0, 6'd0, 6'd0);
        send_beat(alc_pkg::OP_SNOOZE, alc_pkg::FIELD_HOUR, 5'd0, 6'd0, 6'd0);
    endtask

    task automatic test_spare_codes();
        send_beat(OP_SPARE_6, alc_pkg::FIELD_HOUR, 5'd31, 6'd63, 6'd63);
        send_beat(OP_SPARE_7, FIELD_SPARE, 5'd0, 6'd0, 6'd0);
    endtask

    task automatic test_random_traffic(input int count);
        repeat (count) send_random_beat();
    endtask

    // Hold the result side off while beats keep coming, so item_ready drops
    task automatic test_output_backpressure(input int count);
        gaps_on  = 1'b0;
        hold_req = 1'b1;
        repeat (count) send_random_beat();
    endtask

    // Finish with no gaps and no stalls at full rate
    task automatic test_steady_stream(input int count);
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
        repeat (count) send_random_beat();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_field_wrap();
        test_ring_and_stop();
        test_snooze_carry();
        test_spare_codes();
        test_random_traffic(350);
        test_output_backpressure(30);
        test_steady_stream(150);
        item_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        $display("Run covered %0d operations and %0d checked results: %0d alarm starts,",
                 beats_sent, results_checked, alarm_starts);
        $display("%0d snooze/stop returns, %0d long result hold(s), %0d mismatches.",
                 home_requests, long_holds, mismatches);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// File: filelist.f
rtl/alc_pkg.sv
rtl/alc_step.sv
rtl/alarm_clock_controller.sv
rtl/alc_checker.sv
tb/tb_top.sv
